/* hw/rtl/ws_frame_decoder_assert.svh */
// Assertion macros used by the frame decoder checker
`ifndef WS_FRAME_DECODER_ASSERT_SVH
`define WS_FRAME_DECODER_ASSERT_SVH

// Checked on every rising edge outside reset
`define WSFD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included
`define WSFD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/wsfd_pkg.sv */
// Types and constants of the frame decoder
package wsfd_pkg;

   // accumulated length and limit register width
   localparam int ACC_W = 24;

   // first header byte
   localparam logic [7:0] FIN_BIT   = 8'h80;
   localparam logic [7:0] RSV_MASK  = 8'h70;
   localparam logic [7:0] OPC_MASK  = 8'h0F;
   // second header byte
   localparam logic [7:0] MASK_BIT  = 8'h80;
   localparam logic [7:0] LEN7_MASK = 8'h7F;
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   // control frames
   localparam logic [3:0] OPC_CTRL_BIT = 4'h8;
   localparam logic [3:0] OPC_CONT     = 4'h0;
   localparam logic [ACC_W-1:0] CTRL_MAX_LEN = ACC_W'(125);

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_RSV    = 3'd1,
      ERR_CTRL   = 3'd2,
      ERR_LONG   = 3'd3,
      ERR_CONT   = 3'd4,
      ERR_NEWMSG = 3'd5
   } err_code_type;

   // one result transaction
   typedef struct packed {
      logic         has_byte;
      logic [7:0]   data_byte;
      logic [3:0]   msg_opcode;
      logic         ctl_frame;
      logic         message_end;
      err_code_type error_code;
   } result_type;

endpackage

/* hw/rtl/wsfd_parse.sv */
// Frame header parser, length checks, fragment tracking and payload unmasking
module wsfd_parse #(
   parameter int CNT_W = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_fire,
   input  logic [7:0]           in_byte,
   input  logic [CNT_W-1:0]     lim,
   output logic                 res_valid,
   output wsfd_pkg::result_type res
);
   import wsfd_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT16,
      PH_EXT64,
      PH_KEY,
      PH_DATA
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic         fin_ff, fin_in;
   logic [3:0]   opc_ff, opc_in;
   logic         masked_ff, masked_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic         ovf_ff, ovf_in;
   logic         long_ff, long_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic [31:0]  key_ff, key_in;
   logic [1:0]   kidx_ff, kidx_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic         frag_ff, frag_in;
   logic [3:0]   frag_opc_ff, frag_opc_in;
   logic [CNT_W-1:0] frag_tot_ff, frag_tot_in;
   err_code_type err_ff, err_in;

   logic [ACC_W-1:0] acc_sh;
   logic         ovf_sh;
   logic         hdr_done;
   logic [ACC_W-1:0] done_len;
   logic         done_ovf;
   logic [ACC_W-1:0] lim_w;
   logic [ACC_W-1:0] base;
   logic [ACC_W:0]   sum;
   logic         too_long;
   logic         ctl;
   logic [7:0]   key_byte;
   logic [CNT_W-1:0] rem_dec;
   logic         ext_last;

   // big-endian length shift; bits leaving the top mark an oversize length
   assign acc_sh = {acc_ff[ACC_W-9:0], in_byte};
   assign ovf_sh = ovf_ff | (|acc_ff[ACC_W-1:ACC_W-8]);
   assign lim_w  = ACC_W'(lim);
   assign ctl    = |(opc_ff & OPC_CTRL_BIT);
   assign base   = frag_ff ? ACC_W'(frag_tot_ff) : '0;
   assign sum    = {1'b0, base} + {1'b0, done_len};
   assign too_long = done_ovf || (done_len > lim_w);
   assign ext_last = (phase_ff == PH_EXT16 && cnt_ff == 3'd1) ||
                     (phase_ff == PH_EXT64 && cnt_ff == 3'd7);

   // key byte for this payload position, first key byte at position 0
   always_comb begin
      case (kidx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign rem_dec = (rem_ff != '0) ? rem_ff - CNT_W'(1) : rem_ff;

   // next state and result
   always_comb begin
      phase_in    = phase_ff;
      fin_in      = fin_ff;
      opc_in      = opc_ff;
      masked_in   = masked_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      long_in     = long_ff;
      cnt_in      = cnt_ff;
      key_in      = key_ff;
      kidx_in     = kidx_ff;
      rem_in      = rem_ff;
      frag_in     = frag_ff;
      frag_opc_in = frag_opc_ff;
      frag_tot_in = frag_tot_ff;
      err_in      = err_ff;
      hdr_done    = 1'b0;
      done_len    = acc_ff;
      done_ovf    = ovf_ff;
      res_valid   = 1'b0;
      res         = '0;

      if (in_fire && err_ff == ERR_NONE) begin
         case (phase_ff)
            PH_HDR1: begin
               masked_in = |(in_byte & MASK_BIT);
               key_in    = '0;
               kidx_in   = '0;
               acc_in    = '0;
               ovf_in    = 1'b0;
               long_in   = 1'b0;
               cnt_in    = '0;
               if (in_byte[6:0] == LEN7_EXT16) begin
                  phase_in = PH_EXT16;
               end else if (in_byte[6:0] == LEN7_EXT64) begin
                  long_in  = 1'b1;
                  phase_in = PH_EXT64;
               end else begin
                  acc_in = ACC_W'(in_byte & LEN7_MASK);
                  if (masked_in) begin
                     phase_in = PH_KEY;
                  end else begin
                     hdr_done = 1'b1;
                     done_len = ACC_W'(in_byte & LEN7_MASK);
                     done_ovf = 1'b0;
                  end
               end
            end
            PH_EXT16, PH_EXT64: begin
               acc_in = acc_sh;
               ovf_in = ovf_sh;
               cnt_in = cnt_ff + 3'd1;
               if (ext_last) begin
                  if (masked_ff) begin
                     phase_in = PH_KEY;
                  end else begin
                     hdr_done = 1'b1;
                     done_len = acc_sh;
                     done_ovf = ovf_sh;
                  end
               end
            end
            PH_KEY: begin
               key_in  = {key_ff[23:0], in_byte};
               kidx_in = kidx_ff + 2'd1;
               if (kidx_ff == 2'd3) begin
                  hdr_done = 1'b1;
               end
            end
            PH_DATA: begin
               kidx_in = kidx_ff + 2'd1;
               rem_in  = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_HDR0;
               end
               res_valid       = 1'b1;
               res.has_byte    = 1'b1;
               res.data_byte   = in_byte ^ key_byte;
               res.msg_opcode  = ctl ? opc_ff : frag_opc_ff;
               res.ctl_frame   = ctl;
               res.message_end = (rem_dec == '0) && (ctl || fin_ff);
            end
            default: begin
               // first header byte; unused phase codes land here too
               fin_in   = |(in_byte & FIN_BIT);
               opc_in   = 4'(in_byte & OPC_MASK);
               phase_in = PH_HDR1;
               if ((in_byte & RSV_MASK) != 8'h00) begin
                  err_in         = ERR_RSV;
                  res_valid      = 1'b1;
                  res.error_code = ERR_RSV;
               end
            end
         endcase

         // header complete: checks in priority order, then frame set-up
         if (hdr_done) begin
            if (long_in && too_long) begin
               err_in = ERR_LONG;
            end else if (ctl && (!fin_ff || done_len > CTRL_MAX_LEN)) begin
               err_in = ERR_CTRL;
            end else if (too_long) begin
               err_in = ERR_LONG;
            end else if (!ctl && sum > {1'b0, lim_w}) begin
               err_in = ERR_LONG;
            end else if (!ctl && opc_ff == OPC_CONT && !frag_ff) begin
               err_in = ERR_CONT;
            end else if (!ctl && opc_ff != OPC_CONT && frag_ff) begin
               err_in = ERR_NEWMSG;
            end

            if (err_in != ERR_NONE) begin
               res_valid      = 1'b1;
               res.error_code = err_in;
            end else begin
               if (!ctl) begin
                  frag_tot_in = sum[CNT_W-1:0];
                  if (opc_ff != OPC_CONT) begin
                     frag_opc_in = opc_ff;
                  end
                  frag_in = !fin_ff;
               end
               rem_in  = done_len[CNT_W-1:0];
               kidx_in = '0;
               if (done_len != '0) begin
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_HDR0;
                  // empty final or control frame: byte-less end marker
                  if (ctl || fin_ff) begin
                     res_valid       = 1'b1;
                     res.msg_opcode  = ctl ? opc_ff : frag_opc_in;
                     res.ctl_frame   = ctl;
                     res.message_end = 1'b1;
                  end
               end
            end
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR0;
         fin_ff      <= 1'b0;
         opc_ff      <= '0;
         masked_ff   <= 1'b0;
         acc_ff      <= '0;
         ovf_ff      <= 1'b0;
         long_ff     <= 1'b0;
         cnt_ff      <= '0;
         key_ff      <= '0;
         kidx_ff     <= '0;
         rem_ff      <= '0;
         frag_ff     <= 1'b0;
         frag_opc_ff <= '0;
         frag_tot_ff <= '0;
         err_ff      <= ERR_NONE;
      end else begin
         phase_ff    <= phase_in;
         fin_ff      <= fin_in;
         opc_ff      <= opc_in;
         masked_ff   <= masked_in;
         acc_ff      <= acc_in;
         ovf_ff      <= ovf_in;
         long_ff     <= long_in;
         cnt_ff      <= cnt_in;
         key_ff      <= key_in;
         kidx_ff     <= kidx_in;
         rem_ff      <= rem_in;
         frag_ff     <= frag_in;
         frag_opc_ff <= frag_opc_in;
         frag_tot_ff <= frag_tot_in;
         err_ff      <= err_in;
      end
   end

endmodule

/* hw/rtl/wsfd_out.sv */
// Result register between the parser and the result channel
module wsfd_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_load,
   input  wsfd_pkg::result_type res,
   output logic                 space,
   input  logic                 out_ready,
   output logic                 out_valid,
   output wsfd_pkg::result_type out_res
);
   import wsfd_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff;

   // free when empty or being drained this cycle
   assign space = !valid_ff || out_ready;

   always_comb begin
      if (res_load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (res_load) begin
         res_ff <= res;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;

endmodule

/* hw/rtl/ws_frame_decoder.sv */
// Top level of the streaming frame decoder
//
// Channel   Dir  Carries                      Transaction when
// req_*     in   one received byte            req_tvalid && req_tready
// rsp_*     out  payload byte / end / error   rsp_tvalid && rsp_tready
// csr_*     in   max_message_len write        csr_valid && csr_ready
//
// One byte is taken per cycle; its result, if any, shows on rsp_* the next cycle.
// The rate is set by the single result register: req_tready is low only while
// that register holds a result that is not being taken.
// Synchronous active-high reset returns to the first header byte, clears errors
// and sets the length limit to its largest value. csr_ready is always high.
module ws_frame_decoder #(
   parameter int LEN_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [10:8] error_code, [15:11] zero
   output logic [5:0]  rsp_tuser,   // [0] has_byte, [4:1] msg_opcode, [5] ctl_frame
   output logic        rsp_tlast,   // message_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_data     // max_message_len
);
   import wsfd_pkg::*;

   localparam int CNT_W = (LEN_BITS < ACC_W) ? LEN_BITS : ACC_W;
   localparam logic [CNT_W-1:0] CAP = '1;

   logic [CNT_W-1:0] limit_ff, limit_in;
   logic             in_fire;
   logic             res_valid;
   result_type       res;
   result_type       out_res;

   assign csr_ready = 1'b1;

   // effective limit: register value capped at the counter range
   always_comb begin
      if (csr_valid && csr_ready) begin
         limit_in = (csr_data > ACC_W'(CAP)) ? CAP : csr_data[CNT_W-1:0];
      end else begin
         limit_in = limit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CAP;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign in_fire = req_tvalid && req_tready;

   wsfd_parse #(
      .CNT_W (CNT_W)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .in_byte   (req_tdata),
      .lim       (limit_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   wsfd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_load  (res_valid),
      .res       (res),
      .space     (req_tready),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_res   (out_res)
   );

   // result packing
   assign rsp_tdata = {5'b0, out_res.error_code, out_res.data_byte};
   assign rsp_tuser = {out_res.ctl_frame, out_res.msg_opcode, out_res.has_byte};
   assign rsp_tlast = out_res.message_end;

endmodule

/* hw/rtl/wsfd_check.sv */
// Port-level checks of the frame decoder, bound to the top level
`include "ws_frame_decoder_assert.svh"

module wsfd_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [5:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import wsfd_pkg::*;

   logic [2:0]  rsp_err;
   logic [22:0] rsp_all;
   logic [14:0] rsp_rest;
   logic        rsp_stall;
   logic        rsp_fail;
   logic        rsp_bare;

   assign rsp_err   = rsp_tdata[10:8];
   assign rsp_all   = {rsp_tdata, rsp_tuser, rsp_tlast};
   assign rsp_rest  = {rsp_tuser, rsp_tlast, rsp_tdata[7:0]};
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_fail  = rsp_tvalid && rsp_err != ERR_NONE;
   assign rsp_bare  = rsp_tvalid && !rsp_tuser[0] && rsp_err == ERR_NONE;

   // a stalled result holds
   `WSFD_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_all), "stalled result moved")

   // an error result carries nothing but its code
   `WSFD_ASSERT(a_err_bare, rsp_fail |-> rsp_rest == '0, "error result carries other fields")

   // a byte-less result without error is an end marker
   `WSFD_ASSERT(a_empty_end, rsp_bare |-> rsp_tlast && rsp_tdata[7:0] == 8'd0, "bare result not end")

   // control results carry a control opcode
   `WSFD_ASSERT(a_ctl_opc, rsp_tvalid && rsp_tuser[5] |-> rsp_tuser[4], "control with data opcode")

   // nothing leaves straight after reset
   `WSFD_ASSERT_ALWAYS(a_rst_idle, $past(reset) && !reset |-> !rsp_tvalid, "result after reset")

endmodule

bind ws_frame_decoder wsfd_check u_check (.*);

/* verif/tb.sv */
// Self-checking testbench for the streaming WebSocket frame decoder
`timescale 1ns / 100ps

module tb;
   import wsfd_pkg::*;

   // header walk of the mirror, one value per header or length byte, one for the key, one for the payload
   localparam logic [3:0] PH_FIRST      = 4'd0;
   localparam logic [3:0] PH_LEN7       = 4'd1;
   localparam logic [3:0] PH_EXT16      = 4'd2;
   localparam logic [3:0] PH_EXT16_LAST = 4'd3;
   localparam logic [3:0] PH_EXT64      = 4'd4;
   localparam logic [3:0] PH_EXT64_LAST = 4'd11;
   localparam logic [3:0] PH_KEY        = 4'd12;
   localparam logic [3:0] PH_PAYLOAD    = 4'd13;

   // opcodes used by the stimulus
   localparam logic [3:0] OPC_TEXT  = 4'h1;
   localparam logic [3:0] OPC_BIN   = 4'h2;
   localparam logic [3:0] OPC_CLOSE = 4'h8;
   localparam logic [3:0] OPC_PING  = 4'h9;
   localparam logic [3:0] OPC_RSV_C = 4'hF;

   // length encodings in the second header byte
   localparam int FORM_7  = 0;
   localparam int FORM_16 = 1;
   localparam int FORM_64 = 2;

   // frames that end the stream with an error
   localparam int BAD_RSV      = 0;
   localparam int BAD_CTRL_FIN = 1;
   localparam int BAD_CTRL_LEN = 2;
   localparam int BAD_LEN64    = 3;
   localparam int BAD_LEN      = 4;
   localparam int BAD_TOTAL    = 5;
   localparam int BAD_CONT     = 6;
   localparam int BAD_NEWMSG   = 7;

   localparam logic [23:0] LIMIT_MAX   = 24'hFFFFFF;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          HOLD_CYCLES = 300;
   localparam int          PHASE_BYTES = 325;

   // decoder mirror and store of the results it predicts
   class frame_scoreboard;
      logic [23:0]  limit;
      logic [3:0]   phase;
      logic         fin;
      logic [3:0]   opc;
      logic         masked;
      logic         long_len;
      logic [63:0]  len_acc;
      logic [23:0]  remaining;
      logic [31:0]  key;
      logic [1:0]   key_idx;
      logic         open_msg;
      logic [3:0]   msg_opc;
      logic [23:0]  msg_total;
      err_code_type err;
      result_type   decoded_q[$];
      int           mismatches;
      int           results_seen;

      function new();
         limit = LIMIT_MAX;
         phase = PH_FIRST;
         fin = 1'b0;
         opc = '0;
         masked = 1'b0;
         long_len = 1'b0;
         len_acc = '0;
         remaining = '0;
         key = '0;
         key_idx = '0;
         open_msg = 1'b0;
         msg_opc = '0;
         msg_total = '0;
         err = ERR_NONE;
         mismatches = 0;
         results_seen = 0;
      endfunction

      function void set_limit(logic [23:0] v);
         limit = v;
      endfunction

      function void push_result(logic has, logic [7:0] data, logic [3:0] op,
                                logic ctl, logic last, err_code_type code);
         result_type r;
         r.has_byte = has;
         r.data_byte = data;
         r.msg_opcode = op;
         r.ctl_frame = ctl;
         r.message_end = last;
         r.error_code = code;
         decoded_q.push_back(r);
      endfunction

      // errors are sticky: one error result, then silence
      function void flag_error(err_code_type code);
         err = code;
         push_result(1'b0, 8'h00, 4'h0, 1'b0, 1'b0, code);
      endfunction

      // header checks, in the order the decoder applies them
      function void close_header();
         logic [63:0] sum;
         logic        ctl;
         ctl = (opc & OPC_CTRL_BIT) != 0;
         if (long_len && len_acc > 64'(limit)) begin
            flag_error(ERR_LONG);
            return;
         end
         if (ctl) begin
            if (!fin || len_acc > 64'(CTRL_MAX_LEN)) begin
               flag_error(ERR_CTRL);
               return;
            end
            if (len_acc > 64'(limit)) begin
               flag_error(ERR_LONG);
               return;
            end
         end else begin
            if (len_acc > 64'(limit)) begin
               flag_error(ERR_LONG);
               return;
            end
            sum = (open_msg ? 64'(msg_total) : 64'd0) + len_acc;
            if (sum > 64'(limit)) begin
               flag_error(ERR_LONG);
               return;
            end
            if (opc == OPC_CONT) begin
               if (!open_msg) begin
                  flag_error(ERR_CONT);
                  return;
               end
               msg_total = sum[23:0];
            end else begin
               if (open_msg) begin
                  flag_error(ERR_NEWMSG);
                  return;
               end
               msg_opc = opc;
               msg_total = len_acc[23:0];
            end
            open_msg = !fin;
         end
         remaining = len_acc[23:0];
         key_idx = '0;
         if (len_acc != 0) begin
            phase = PH_PAYLOAD;
            return;
         end
         // empty frame: end marker unless it is a non-final data fragment
         phase = PH_FIRST;
         if (ctl)
            push_result(1'b0, 8'h00, opc, 1'b1, 1'b1, ERR_NONE);
         else if (fin)
            push_result(1'b0, 8'h00, msg_opc, 1'b0, 1'b1, ERR_NONE);
      endfunction

      // one accepted request transaction
      function void decode_byte(logic [7:0] b);
         logic       ctl;
         logic [7:0] plain;
         if (err != ERR_NONE)
            return;
         if (phase == PH_LEN7) begin
            masked = b[7];
            key = '0;
            key_idx = '0;
            len_acc = '0;
            long_len = 1'b0;
            if (b[6:0] == LEN7_EXT16) begin
               phase = PH_EXT16;
            end else if (b[6:0] == LEN7_EXT64) begin
               long_len = 1'b1;
               phase = PH_EXT64;
            end else begin
               len_acc = 64'(b[6:0]);
               if (masked)
                  phase = PH_KEY;
               else
                  close_header();
            end
         end else if (phase >= PH_EXT16 && phase <= PH_EXT64_LAST) begin
            // big-endian extended length
            len_acc = {len_acc[55:0], b};
            if (phase == PH_EXT16_LAST || phase == PH_EXT64_LAST) begin
               if (masked)
                  phase = PH_KEY;
               else
                  close_header();
            end else begin
               phase = phase + 4'd1;
            end
         end else if (phase == PH_KEY) begin
            key = {key[23:0], b};
            key_idx = key_idx + 2'd1;
            if (key_idx == 2'd0)
               close_header();
         end else if (phase == PH_PAYLOAD) begin
            ctl = (opc & OPC_CTRL_BIT) != 0;
            plain = b ^ key[8*(3-key_idx) +: 8];
            key_idx = key_idx + 2'd1;
            if (remaining != 0)
               remaining = remaining - 24'd1;
            if (remaining == 0)
               phase = PH_FIRST;
            push_result(1'b1, plain, ctl ? opc : msg_opc, ctl,
                        (remaining == 0) && (ctl || fin), ERR_NONE);
         end else begin
            // first header byte; unused phase values land here too
            fin = b[7];
            opc = b[3:0];
            phase = PH_LEN7;
            if ((b & RSV_MASK) != 0)
               flag_error(ERR_RSV);
         end
      endfunction

      function string fmt(result_type r);
         return $sformatf("has=%0d data=%02h op=%0d ctl=%0d end=%0d err=%0d",
                          r.has_byte, r.data_byte, r.msg_opcode, r.ctl_frame,
                          r.message_end, r.error_code);
      endfunction

      // one accepted response transaction against the oldest prediction
      function void check_result(result_type got);
         result_type want;
         results_seen++;
         if (decoded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result, nothing pending: %s", fmt(got));
            return;
         end
         want = decoded_q.pop_front();
         if (got.has_byte !== want.has_byte || got.data_byte !== want.data_byte ||
             got.msg_opcode !== want.msg_opcode || got.ctl_frame !== want.ctl_frame ||
             got.message_end !== want.message_end || got.error_code !== want.error_code)
         begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result %0d mismatch, expected %s", results_seen, fmt(want));
               $display("                    actual   %s", fmt(got));
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // [7:0] data_byte, [10:8] error_code, [15:11] zero
   logic [5:0]  rsp_tuser;   // [0] has_byte, [4:1] msg_opcode, [5] ctl_frame
   logic        rsp_tlast;   // message_end
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [23:0] csr_data = 24'h000000;

   frame_scoreboard sb = new();

   int  cycle_count = 0;
   int  n_bytes = 0;
   int  n_frames = 0;
   int  burst_left = 0;
   int  cur_limit = 24'hFFFFFF;
   bit  hold_arm = 1'b0;
   bit  hold_off = 1'b0;
   int  stall_mode = 0;
   int  stall_left = 0;
   int  stall_tick = 0;
   bit  ready_bit;

   ws_frame_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: check accepted transactions, stall in changing modes
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result({rsp_tuser[0], rsp_tdata[7:0], rsp_tuser[4:1], rsp_tuser[5],
                          rsp_tlast, rsp_tdata[10:8]});
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(10, 80);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         0: ready_bit = 1'b1;
         1: ready_bit = ($urandom_range(0, 3) != 0);
         2: ready_bit = ($urandom_range(0, 3) == 0);
         default: ready_bit = (stall_tick % 3 == 0);
      endcase
      rsp_tready <= !hold_off && ready_bit;
   end

   // one long receiver hold-off while bytes keep coming
   initial begin
      wait (hold_arm);
      repeat ($urandom_range(20, 120)) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // offer one byte; bursts of random length with random gaps between them
   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(5, 20)) @(posedge clock);
         else
            repeat ($urandom_range(1, 4)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      n_bytes++;
      sb.decode_byte(b);
   endtask

   // stop sending until every predicted result is out, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.decoded_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [23:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_limit = v;
      sb.set_limit(v);
   endtask

   task automatic send_header(input logic fin, input logic [2:0] rsv, input logic [3:0] opc,
                              input logic masked, input int form, input logic [63:0] plen);
      send_byte({fin, rsv, opc});
      case (form)
         FORM_7: send_byte({masked, plen[6:0]});
         FORM_16: begin
            send_byte({masked, LEN7_EXT16});
            send_byte(plen[15:8]);
            send_byte(plen[7:0]);
         end
         default: begin
            send_byte({masked, LEN7_EXT64});
            for (int i = 7; i >= 0; i--)
               send_byte(plen[8*i +: 8]);
         end
      endcase
      if (masked)
         repeat (4) send_byte(8'($urandom));
      n_frames++;
   endtask

   // well-formed frame with random mask, encoding and payload
   task automatic send_frame(input logic fin, input logic [3:0] opc, input int plen);
      int form;
      if (plen <= 125)
         form = ($urandom_range(0, 5) < 4) ? FORM_7 : $urandom_range(FORM_16, FORM_64);
      else if (plen <= 65535)
         form = $urandom_range(FORM_16, FORM_64);
      else
         form = FORM_64;
      send_header(fin, 3'b000, opc, 1'($urandom), form, 64'(plen));
      repeat (plen) send_byte(8'($urandom));
   endtask

   // mostly short payloads, some empty, a few long; never past room
   function automatic int pick_len(input int room);
      int r;
      int n;
      r = $urandom_range(0, 19);
      if (r < 3)
         n = 0;
      else if (r < 16)
         n = $urandom_range(1, 10);
      else if (r < 19)
         n = $urandom_range(11, 130);
      else
         n = $urandom_range(131, 400);
      return (n > room) ? room : n;
   endfunction

   // text and binary common, reserved data opcodes now and then
   function automatic logic [3:0] pick_data_opc();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return OPC_TEXT;
      else if (r < 8)
         return OPC_BIN;
      return 4'($urandom_range(3, 7));
   endfunction

   // a control frame, or a data message in one or more fragments with
   // control frames slipped in between
   task automatic send_message();
      int         nfrag;
      int         room;
      int         plen;
      logic [3:0] opc;
      if ($urandom_range(0, 3) == 0) begin
         send_frame(1'b1, 4'($urandom_range(8, 15)), pick_len(int'(CTRL_MAX_LEN)));
      end else begin
         opc = pick_data_opc();
         nfrag = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 5) : 1;
         room = cur_limit;
         for (int f = 0; f < nfrag; f++) begin
            plen = pick_len(room);
            room -= plen;
            send_frame(f == nfrag - 1, (f == 0) ? opc : OPC_CONT, plen);
            if (f < nfrag - 1 && $urandom_range(0, 2) == 0)
               send_frame(1'b1, 4'($urandom_range(8, 15)), pick_len(int'(CTRL_MAX_LEN)));
         end
      end
   endtask

   // a frame that breaks the stream; any error locks the decoder until reset
   task automatic send_bad_frame(input int kind);
      int          p1;
      logic [63:0] big;
      case (kind)
         BAD_RSV:
            send_byte({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
         BAD_CTRL_FIN:
            send_header(1'b0, 3'b000, 4'($urandom_range(8, 15)), 1'($urandom), FORM_7,
                        64'($urandom_range(0, 125)));
         BAD_CTRL_LEN:
            send_header(1'b1, 3'b000, 4'($urandom_range(8, 15)), 1'($urandom), FORM_16,
                        64'($urandom_range(126, 2000)));
         BAD_LEN64: begin
            big = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 0 || big <= 64'(cur_limit))
               big = 64'(cur_limit) + 64'($urandom_range(1, 1000));
            send_header(1'($urandom), 3'b000, 4'($urandom), 1'($urandom), FORM_64, big);
         end
         BAD_LEN:
            send_header(1'($urandom), 3'b000, pick_data_opc(), 1'($urandom), FORM_16,
                        64'(cur_limit + $urandom_range(1, 50)));
         BAD_TOTAL: begin
            // fragments each within the limit, together past it
            p1 = $urandom_range(1, cur_limit);
            send_frame(1'b0, pick_data_opc(), p1);
            send_header(1'($urandom), 3'b000, OPC_CONT, 1'($urandom), FORM_16,
                        64'($urandom_range(cur_limit - p1 + 1, cur_limit)));
         end
         BAD_CONT:
            send_header(1'($urandom), 3'b000, OPC_CONT, 1'($urandom), FORM_7,
                        64'($urandom_range(0, 20)));
         default: begin
            send_frame(1'b0, pick_data_opc(), pick_len(20));
            send_header(1'($urandom), 3'b000, pick_data_opc(), 1'($urandom), FORM_7,
                        64'($urandom_range(0, 20)));
         end
      endcase
   endtask

   initial begin
      logic [23:0] phase_limit [4];
      bit          paused;
      int          target;

      paused = 1'b0;
      phase_limit[0] = 24'd125;
      phase_limit[1] = LIMIT_MAX;
      phase_limit[2] = 24'($urandom_range(126, 16777214));
      phase_limit[3] = 24'($urandom_range(125, 300));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed frames at the reset limit
      send_header(1'b1, 3'b000, OPC_TEXT, 1'b0, FORM_7, 64'd1);
      send_byte(8'hFF);
      send_header(1'b1, 3'b000, OPC_BIN, 1'b1, FORM_7, 64'd2);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_header(1'b1, 3'b000, OPC_PING, 1'b0, FORM_7, 64'd0);
      send_header(1'b0, 3'b000, OPC_TEXT, 1'b0, FORM_16, 64'd1);
      send_byte(8'h5A);
      send_header(1'b1, 3'b000, OPC_CONT, 1'b0, FORM_7, 64'd0);
      send_header(1'b1, 3'b000, OPC_RSV_C, 1'b0, FORM_64, 64'd0);
      send_header(1'b1, 3'b000, OPC_CLOSE, 1'b1, FORM_7, 64'd0);

      // random messages under each limit setting
      foreach (phase_limit[p]) begin
         drain();
         write_limit(phase_limit[p]);
         if (p == 0)
            hold_arm = 1'b1;
         target = n_bytes + PHASE_BYTES;
         while (n_bytes < target) begin
            send_message();
            if (p == 1 && !paused && n_bytes > target - PHASE_BYTES / 2) begin
               drain();
               paused = 1'b1;
            end
         end
      end

      // break the stream once, then trailing bytes that must be ignored
      send_bad_frame($urandom_range(BAD_RSV, BAD_NEWMSG));
      repeat (30) send_byte(8'($urandom));
      drain();

      $display("Sent %0d bytes in %0d frames; %0d results checked across five limits.",
               n_bytes, n_frames, sb.results_seen);
      $display("Stream closed on error %s with the trailing bytes ignored.",
               sb.err.name());
      if (sb.mismatches == 0 && sb.decoded_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches, %0d results still pending",
                  sb.mismatches, sb.decoded_q.size());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/wsfd_pkg.sv
hw/rtl/wsfd_parse.sv
hw/rtl/wsfd_out.sv
hw/rtl/ws_frame_decoder.sv
hw/rtl/wsfd_check.sv
verif/tb.sv
